// ===== rtl/core/drl_pkg.sv =====
// ----------------------------------------------------------------------------
// drl_pkg
// Shared types and constants of the descriptor register-list loader.
// ----------------------------------------------------------------------------
`default_nettype none

package drl_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned AddrW      = 64;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned CountW     = 6;
  localparam int unsigned ValsLeftW  = 7;
  localparam int unsigned BaseIdxW   = 24;
  localparam int unsigned RegIdxW    = 25;

  localparam logic [SlotW-1:0] HdrWordsBase = 4'd10;
  localparam logic [SlotW-1:0] HdrWordsExt  = 4'd11;
  localparam logic [SlotW-1:0] ExtFlagSlot  = 4'd6;
  localparam int unsigned      ExtFlagBit   = 24;
  localparam int unsigned      CountLsb     = 26;
  localparam int unsigned      BaseIdxLsb   = 2;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_BLOCK  = 2'd2,
    KIND_SHORT  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             word_last;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [SlotW-1:0] header_slot;
    logic [AddrW-1:0] write_address;
    logic [WordW-1:0] payload;
    logic             done_res;
    logic             truncated;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/drl_if.sv =====
// ----------------------------------------------------------------------------
// drl_if
// Valid/ready stream interfaces for descriptor words and loader results.
// ----------------------------------------------------------------------------
`default_nettype none

interface drl_in_if
  import drl_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface drl_out_if
  import drl_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/descriptor_register_list_loader.sv =====
// Path: each accepted word is held in the input register, then decoded into the result register.
// Throughput: one descriptor word per cycle; a full input register waits only while
// the result register holds an item that is not taken.
// Reset (rst_ni low, async): pipeline empty, header/block state cleared,
// window_base cleared to zero.
// ----------------------------------------------------------------------------
// descriptor_register_list_loader
// Walks a task descriptor word by word: forwards header words, decodes
// register blocks into addressed writes, flags short or cut-off descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_register_list_loader
  import drl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [AddrW-1:0] cfg_wdata_i,
  drl_in_if.sink                in_if,
  drl_out_if.source             out_if
);

  logic [AddrW-1:0]     window_base_q;

  // input stage
  logic                 in_vld_q;
  in_item_t             in_item_q;

  // descriptor state
  logic [SlotW-1:0]     hdr_seen_q, hdr_seen_d;
  logic                 ext_hdr_q, ext_hdr_d;
  logic [ValsLeftW-1:0] vals_left_q, vals_left_d;
  logic [RegIdxW-1:0]   reg_idx_q, reg_idx_d;

  // result stage
  logic                 out_vld_q;
  out_item_t            out_item_q, out_item_d;

  logic                 s2_free;
  logic                 advance;

  assign s2_free      = !out_vld_q || out_if.ready;
  assign advance      = in_vld_q && s2_free;
  assign in_if.ready  = !in_vld_q || s2_free;

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q <= '0;
    end else if (cfg_we_i) begin
      window_base_q <= cfg_wdata_i;
    end
  end

  // Per-word decode.
  always_comb begin
    logic [SlotW-1:0] need;
    logic [SlotW-1:0] need_n;
    logic [WordW-1:0] w;
    logic             last;

    w    = in_item_q.word;
    last = in_item_q.word_last;
    need = ext_hdr_q ? HdrWordsExt : HdrWordsBase;

    hdr_seen_d  = hdr_seen_q;
    ext_hdr_d   = ext_hdr_q;
    vals_left_d = vals_left_q;
    reg_idx_d   = reg_idx_q;

    out_item_d.kind          = KIND_HEADER;
    out_item_d.header_slot   = '0;
    out_item_d.write_address = '0;
    out_item_d.payload       = w;
    out_item_d.done_res      = last;
    out_item_d.truncated     = 1'b0;

    if (hdr_seen_q < need) begin
      out_item_d.header_slot = hdr_seen_q;
      if (hdr_seen_q == ExtFlagSlot) begin
        ext_hdr_d = w[ExtFlagBit];
      end
      hdr_seen_d = hdr_seen_q + 1'b1;
      need_n     = ext_hdr_d ? HdrWordsExt : HdrWordsBase;
      out_item_d.kind = (last && (hdr_seen_d < need_n)) ? KIND_SHORT : KIND_HEADER;
    end else if (vals_left_q == '0) begin
      need_n      = need;
      vals_left_d = {1'b0, w[CountLsb +: CountW]} + 1'b1;
      reg_idx_d   = {1'b0, w[BaseIdxLsb +: BaseIdxW]};
      out_item_d.kind      = KIND_BLOCK;
      out_item_d.truncated = last;
    end else begin
      need_n      = need;
      out_item_d.write_address =
        window_base_q + {{(AddrW-RegIdxW-2){1'b0}}, reg_idx_q, 2'b00};
      reg_idx_d   = reg_idx_q + 1'b1;
      vals_left_d = vals_left_q - 1'b1;
      out_item_d.kind      = KIND_WRITE;
      out_item_d.truncated = last && (vals_left_d != '0);
    end

    // end of descriptor: start over
    if (last) begin
      hdr_seen_d  = '0;
      ext_hdr_d   = 1'b0;
      vals_left_d = '0;
      reg_idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      hdr_seen_q  <= '0;
      ext_hdr_q   <= 1'b0;
      vals_left_q <= '0;
      reg_idx_q   <= '0;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (s2_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        hdr_seen_q  <= hdr_seen_d;
        ext_hdr_q   <= ext_hdr_d;
        vals_left_q <= vals_left_d;
        reg_idx_q   <= reg_idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_item_q <= in_if.payload;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

`ifndef ASSERT_OFF
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !s2_free |=> in_vld_q && $stable(in_item_q))
    else $error("input stage lost a word while stalled");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_item_q.word_last |=>
      hdr_seen_q == '0 && vals_left_q == '0 && reg_idx_q == '0 && !ext_hdr_q)
    else $error("state not cleared after last word");

  a_addr_only_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_item_q.kind != KIND_WRITE |-> out_item_q.write_address == '0)
    else $error("address on a non-write result");

  a_slot_only_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_item_q.kind == KIND_WRITE || out_item_q.kind == KIND_BLOCK)
      |-> out_item_q.header_slot == '0)
    else $error("header slot on a block result");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for descriptor_register_list_loader. Descriptor words go in over
// valid/ready; every accepted word is run through a scoreboard that tracks
// header, extended header and register block state and queues the result
// item it must produce. Results are compared field by field in order.
// Phases vary the window base and the idling on both sides, including a long
// output hold that backs the block up.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import drl_pkg::*;

  localparam int HoldCycles = 300;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts one result per descriptor word
  // --------------------------------------------------------------------------
  class loader_scoreboard;
    logic [AddrW-1:0]     window_base;
    logic [SlotW-1:0]     hdr_seen;
    logic                 ext_hdr;
    logic [ValsLeftW-1:0] vals_left;
    logic [RegIdxW-1:0]   reg_index;
    out_item_t            expected_q[$];
    int                   errors;
    int                   checked;

    function new();
      window_base = '0;
      errors      = 0;
      checked     = 0;
      clear_desc();
    endfunction

    function void clear_desc();
      hdr_seen  = '0;
      ext_hdr   = 1'b0;
      vals_left = '0;
      reg_index = '0;
    endfunction

    function void note_word(in_item_t it);
      out_item_t        res;
      logic [SlotW-1:0] need;
      res          = '0;
      res.payload  = it.word;
      res.done_res = it.word_last;
      need = ext_hdr ? HdrWordsExt : HdrWordsBase;
      if (hdr_seen < need) begin
        res.header_slot = hdr_seen;
        if (hdr_seen == ExtFlagSlot) ext_hdr = it.word[ExtFlagBit];
        hdr_seen = hdr_seen + 4'd1;
        need = ext_hdr ? HdrWordsExt : HdrWordsBase;
        if (it.word_last && hdr_seen < need) res.kind = KIND_SHORT;
        else res.kind = KIND_HEADER;
      end else if (vals_left == '0) begin
        // block header: count + 1 values follow
        vals_left     = {1'b0, it.word[WordW-1:CountLsb]} + 7'd1;
        reg_index     = {1'b0, it.word[CountLsb-1:BaseIdxLsb]};
        res.kind      = KIND_BLOCK;
        res.truncated = it.word_last;
      end else begin
        res.write_address = window_base + {37'd0, reg_index, 2'b00};
        reg_index         = reg_index + 25'd1;
        vals_left         = vals_left - 7'd1;
        res.kind          = KIND_WRITE;
        res.truncated     = it.word_last && (vals_left != '0);
      end
      expected_q.push_back(res);
      if (it.word_last) clear_desc();
    endfunction

    task report(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, payload %h", got.payload));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.header_slot !== want.header_slot)
        report($sformatf("header_slot %0d, want %0d", got.header_slot, want.header_slot));
      if (got.write_address !== want.write_address)
        report($sformatf("write_address %h, want %h", got.write_address,
                         want.write_address));
      if (got.payload !== want.payload)
        report($sformatf("payload %h, want %h", got.payload, want.payload));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res %b, want %b", got.done_res, want.done_res));
      if (got.truncated !== want.truncated)
        report($sformatf("truncated %b, want %b", got.truncated, want.truncated));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [AddrW-1:0] cfg_wdata_i;

  drl_in_if  in_ch ();
  drl_out_if out_ch ();

  always #10 clk_i = ~clk_i;

  descriptor_register_list_loader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  loader_scoreboard sb = new();

  in_item_t desc_q[$];
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_req;
  int       hold_done;
  int       hold_left;
  int       words_sent;
  int       descs_sent;

  // --------------------------------------------------------------------------
  // Monitors and output side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_word(in_ch.payload);
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  // receiver: random stalls, plus a long hold whenever one is requested
  always @(posedge clk_i) begin
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_word(logic [WordW-1:0] w, logic last);
    in_item_t it;
    it.word      = w;
    it.word_last = last;
    desc_q.push_back(it);
  endfunction

  function automatic logic [WordW-1:0] block_word(logic [CountW-1:0] cnt,
                                                  logic [BaseIdxW-1:0] idx);
    logic [1:0] low;
    low = 2'($urandom_range(0, 3));
    return {cnt, idx, low};
  endfunction

  // well-formed descriptor with random content
  function automatic void build_desc();
    logic             ext;
    logic [WordW-1:0] w;
    logic [CountW-1:0] cnt;
    int               n_blk;
    desc_q.delete();
    ext = 1'($urandom_range(0, 1));
    for (int i = 0; i < (ext ? 11 : 10); i++) begin
      w = $urandom;
      if (i == ExtFlagSlot) w[ExtFlagBit] = ext;
      push_word(w, 1'b0);
    end
    n_blk = $urandom_range(0, 3);
    for (int b = 0; b < n_blk; b++) begin
      if ($urandom_range(0, 9) == 0) cnt = 6'($urandom_range(0, 63));
      else cnt = 6'($urandom_range(0, 3));
      push_word(block_word(cnt, BaseIdxW'($urandom)), 1'b0);
      for (int j = 0; j <= cnt; j++) push_word($urandom, 1'b0);
    end
    desc_q[desc_q.size()-1].word_last = 1'b1;
  endfunction

  function automatic void build_random_desc();
    int pick;
    int keep;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      build_desc();
    end else if (pick < 85) begin
      // cut short anywhere: short header, block header last, mid-block
      build_desc();
      keep = $urandom_range(1, desc_q.size());
      while (desc_q.size() > keep) void'(desc_q.pop_back());
      desc_q[keep-1].word_last = 1'b1;
    end else begin
      desc_q.delete();
      repeat ($urandom_range(1, 16)) push_word($urandom, ($urandom_range(0, 5) == 0));
      desc_q[desc_q.size()-1].word_last = 1'b1;
    end
  endfunction

  task automatic send_word(in_item_t it);
    // each idle cycle is taken with probability send_idle_pct
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_desc();
    foreach (desc_q[i]) send_word(desc_q[i]);
    descs_sent++;
  endtask

  // stop offering and let every pending result come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_base(logic [AddrW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    sb.window_base  = v;
    @(posedge clk_i);
  endtask

  task automatic run_random(int quota);
    int start;
    start = words_sent;
    while (words_sent - start < quota) begin
      build_random_desc();
      send_desc();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    hold_done      = 0;
    hold_left      = 0;
    words_sent     = 0;
    descs_sent     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extended header, block at top index, address wrap, cut mid-block
    write_base(64'hFFFF_FFFF_FFFF_FFFC);
    desc_q.delete();
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    for (int i = 2; i < ExtFlagSlot; i++) push_word($urandom, 1'b0);
    push_word(32'h0100_0000, 1'b0);
    for (int i = 7; i < 10; i++) push_word($urandom, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(block_word(6'd1, 24'hFF_FFFF), 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    send_desc();

    // directed: last word on header word 6 with the extension flag set
    desc_q.delete();
    for (int i = 0; i < ExtFlagSlot; i++) push_word($urandom, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
    send_desc();

    // directed: plain header, then a max-count block header as last word
    desc_q.delete();
    for (int i = 0; i < 10; i++)
      push_word((i == ExtFlagSlot) ? 32'hFEFF_FFFF : $urandom, 1'b0);
    push_word(block_word(6'h3F, 24'h00_0000), 1'b1);
    send_desc();
    wait_idle();

    // no idling
    write_base({$urandom, $urandom});
    run_random(85);
    wait_idle();

    // sender idles
    write_base(64'hFFFF_FFFF_FFFF_FFFF);
    send_idle_pct = 54;
    run_random(85);
    wait_idle();

    // receiver stalls
    write_base(64'h0);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    run_random(85);
    wait_idle();

    // long output hold while input keeps coming, then both sides idle
    write_base({$urandom, $urandom});
    recv_stall_pct = 25;
    hold_req++;
    begin
      int start;
      start = words_sent;
      while (words_sent - start < 30) begin
        build_desc();
        send_desc();
      end
    end
    wait_idle();
    send_idle_pct = 25;
    run_random(90);
    wait_idle();

    repeat (4) @(posedge clk_i);
    $display("run covered %0d words in %0d descriptors, %0d results checked",
             words_sent, descs_sent, sb.checked);
    $display("window base at zero, all ones and random; output held %0d cycles once",
             HoldCycles);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
